FILE: hdl/mlfq_pkg.sv
// Shared types, codes and constants of the three-level feedback queue dispatcher.
// Used by mlfq_proc_table, mlfq_apb_regs and the dispatcher core; depends on nothing.
package mlfq_pkg;

    localparam int NUM_PROCS_DEF  = 8;
    localparam int BURST_BITS_DEF = 16;
    localparam int BURST_MAX      = 32;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [15:0] QUANTUM_FIRST_RST  = 16'd5;
    localparam logic [15:0] QUANTUM_SECOND_RST = 16'd10;

    typedef logic [1:0] t_lvl;
    localparam t_lvl LVL_TOP = 2'd0;
    localparam t_lvl LVL_MID = 2'd1;
    localparam t_lvl LVL_LOW = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_EMPTY  = 2'd1;
    localparam t_status ST_REJECT = 2'd2;

    localparam logic REQ_READY    = 1'b0;
    localparam logic REQ_DISPATCH = 1'b1;

    localparam logic REG_QUANTUM_FIRST  = 1'b0;
    localparam logic REG_QUANTUM_SECOND = 1'b1;

    // per-process table write, all fields go to the same process slot
    typedef struct packed {
        logic                 en_rem;
        logic [BURST_MAX-1:0] rem;
        logic                 en_last;
        logic [31:0]          last;
        logic                 en_lvl;
        t_lvl                 lvl;
        logic                 en_q;
        logic                 q_val;
        logic                 en_ever;
    } t_tbl_wr;

endpackage

FILE: hdl/mlfq_level_fifo.sv
// One level queue: circular buffer of process numbers with head pointer and fill count.
// Depends on nothing but its parameter.
module mlfq_level_fifo #(
    parameter int DEPTH = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  logic [$clog2(DEPTH)-1:0]         i_push_id,
    input  logic                             i_pop,
    output logic [$clog2(DEPTH)-1:0]         o_head_id,
    output logic                             o_empty,
    output logic [$clog2(DEPTH+1)-1:0]       o_count
);

    localparam int PID_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    logic [PID_W-1:0] r_slot [DEPTH];
    logic [PID_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic [SUM_W-1:0] w_tail_sum;
    logic [PID_W-1:0] w_tail;
    logic             w_push_ok;
    logic             w_pop_ok;

    always_comb begin
        w_tail_sum = SUM_W'(r_head) + SUM_W'(r_count);
        if (w_tail_sum >= SUM_W'(DEPTH)) begin
            w_tail = PID_W'(w_tail_sum - SUM_W'(DEPTH));
        end else begin
            w_tail = PID_W'(w_tail_sum);
        end
        w_push_ok = i_push && (r_count < CNT_W'(DEPTH));
        w_pop_ok  = i_pop && (r_count != '0);
        n_head    = r_head;
        if (w_pop_ok) begin
            n_head = (r_head == PID_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
        end
        n_count = r_count + CNT_W'(w_push_ok) - CNT_W'(w_pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_slot[w_tail] <= i_push_id;
        end
    end

    assign o_head_id = r_slot[r_head];
    assign o_empty   = (r_count == '0);
    assign o_count   = r_count;

endmodule

FILE: hdl/mlfq_proc_table.sv
// Per-process state: level, queued and ever-ran flags, remaining burst, last ready time.
// Depends on mlfq_pkg (t_lvl, t_tbl_wr).
module mlfq_proc_table #(
    parameter int NUM_PROCS  = mlfq_pkg::NUM_PROCS_DEF,
    parameter int BURST_BITS = mlfq_pkg::BURST_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [$clog2(NUM_PROCS)-1:0]  i_addr,
    input  logic                          i_wr_en,
    input  mlfq_pkg::t_tbl_wr             i_wr,
    output mlfq_pkg::t_lvl                o_lvl,
    output logic                          o_queued,
    output logic                          o_ever,
    output logic [BURST_BITS-1:0]         o_rem,
    output logic [31:0]                   o_last,
    output logic [NUM_PROCS-1:0]          o_queued_vec
);

    logic [BURST_BITS-1:0] r_rem  [NUM_PROCS];
    logic [31:0]           r_last [NUM_PROCS];
    mlfq_pkg::t_lvl        r_lvl  [NUM_PROCS];
    logic [NUM_PROCS-1:0]  r_queued;
    logic [NUM_PROCS-1:0]  r_ever;

    // flags and levels have a defined reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queued <= '0;
            r_ever   <= '0;
            for (int i = 0; i < NUM_PROCS; i++) begin
                r_lvl[i] <= mlfq_pkg::LVL_TOP;
            end
        end else if (i_wr_en) begin
            if (i_wr.en_q) begin
                r_queued[i_addr] <= i_wr.q_val;
            end
            if (i_wr.en_ever) begin
                r_ever[i_addr] <= 1'b1;
            end
            if (i_wr.en_lvl) begin
                r_lvl[i_addr] <= i_wr.lvl;
            end
        end
    end

    // burst and ready time are always written before any read
    always_ff @(posedge i_clk) begin
        if (i_wr_en && i_wr.en_rem) begin
            r_rem[i_addr] <= BURST_BITS'(i_wr.rem);
        end
        if (i_wr_en && i_wr.en_last) begin
            r_last[i_addr] <= i_wr.last;
        end
    end

    assign o_lvl        = r_lvl[i_addr];
    assign o_queued     = r_queued[i_addr];
    assign o_ever       = r_ever[i_addr];
    assign o_rem        = r_rem[i_addr];
    assign o_last       = r_last[i_addr];
    assign o_queued_vec = r_queued;

endmodule

FILE: hdl/mlfq_apb_regs.sv
// APB register file holding the level 0 and level 1 time slices.
// Depends on mlfq_pkg (address width, register indexes, reset values).
module mlfq_apb_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mlfq_pkg::APB_AW-1:0] paddr,
    input  logic [mlfq_pkg::APB_DW-1:0] pwdata,
    output logic [mlfq_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output logic [15:0]                 o_quantum_first,
    output logic [15:0]                 o_quantum_second
);

    logic [15:0] r_q_first;
    logic [15:0] r_q_second;
    logic        w_wr;
    logic        w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_first  <= mlfq_pkg::QUANTUM_FIRST_RST;
            r_q_second <= mlfq_pkg::QUANTUM_SECOND_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                mlfq_pkg::REG_QUANTUM_FIRST:  r_q_first  <= pwdata[15:0];
                mlfq_pkg::REG_QUANTUM_SECOND: r_q_second <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            mlfq_pkg::REG_QUANTUM_FIRST:  prdata = {16'd0, r_q_first};
            mlfq_pkg::REG_QUANTUM_SECOND: prdata = {16'd0, r_q_second};
            default:                      prdata = '0;
        endcase
    end

    assign o_quantum_first  = r_q_first;
    assign o_quantum_second = r_q_second;

endmodule

FILE: hdl/mlfq_three_level_dispatcher_core.sv
// Three-level feedback queue dispatcher: top level with input/result registers and decision logic.
// Depends on mlfq_pkg, mlfq_level_fifo, mlfq_proc_table, mlfq_apb_regs.
//
// Every transaction on the slave stream gives exactly one result transaction. A ready request
// (tuser 0) places a process not yet queued in the queue of its current level; a dispatch
// request (tuser 1) serves the head of the highest non-empty queue, advances the CPU clock over
// any idle gap and the slice, and demotes an unfinished burst one level. One request is taken
// per clock unless the result stream back-pressures; it passes the input register and then the
// result register, where its result can wait while the next request is held. Table and queues
// take one read-modify-write per request. Quanta are to be written over APB at 0x0 and 0x4 only
// while the block is idle; the block does not enforce it. No clearing pass is needed after reset.
module mlfq_three_level_dispatcher_core #(
    parameter int NUM_PROCS  = mlfq_pkg::NUM_PROCS_DEF,
    parameter int BURST_BITS = mlfq_pkg::BURST_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [2:0] proc_id, [18:3] burst_length, [50:19] ready_time, [55:51] zero
    input  logic [55:0]                 s_axis_tdata,
    // [0] req_type
    input  logic                        s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [2:0] run_proc, [4:3] run_level, [36:5] start_time, [52:37] run_length,
    // [53] burst_finished, [54] demoted, [86:55] wait_added, [87] first_run,
    // [119:88] idle_total
    output logic [119:0]                m_axis_tdata,
    // [1:0] status
    output logic [1:0]                  m_axis_tuser,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mlfq_pkg::APB_AW-1:0] paddr,
    input  logic [mlfq_pkg::APB_DW-1:0] pwdata,
    output logic [mlfq_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    localparam int PID_W = $clog2(NUM_PROCS);
    localparam int CNT_W = $clog2(NUM_PROCS + 1);
    localparam int LEVELS = 3;

    // input register
    logic                  r_in_valid;
    logic                  r_in_type;
    logic [2:0]            r_in_pid;
    logic [15:0]           r_in_burst;
    logic [31:0]           r_in_rtime;

    // result register
    logic                  r_out_valid;
    logic [119:0]          r_out_data;
    mlfq_pkg::t_status     r_out_status;

    logic [31:0]           r_clock, n_clock;
    logic [31:0]           r_idle, n_idle;

    logic                  w_fire;
    logic                  w_load;

    logic [15:0]           w_q_first;
    logic [15:0]           w_q_second;

    logic [LEVELS-1:0]     w_empty;
    logic [PID_W-1:0]      w_head [LEVELS];
    logic [CNT_W-1:0]      w_count [LEVELS];
    logic                  w_push;
    mlfq_pkg::t_lvl        w_push_lvl;
    logic [PID_W-1:0]      w_push_id;
    logic                  w_pop;
    mlfq_pkg::t_lvl        w_sel_lvl;

    logic [PID_W-1:0]      w_addr;
    logic [PID_W-1:0]      w_pid_in;
    logic                  w_in_range;
    logic                  w_tbl_we;
    mlfq_pkg::t_tbl_wr     w_tbl_wr;
    mlfq_pkg::t_lvl        w_rd_lvl;
    logic                  w_rd_queued;
    logic                  w_rd_ever;
    logic [BURST_BITS-1:0] w_rd_rem;
    logic [31:0]           w_rd_last;
    logic [NUM_PROCS-1:0]  w_queued_vec;

    // result fields
    mlfq_pkg::t_status     w_status;
    logic [2:0]            w_run_proc;
    mlfq_pkg::t_lvl        w_run_level;
    logic [31:0]           w_start;
    logic [15:0]           w_run_len;
    logic                  w_fin;
    logic                  w_dem;
    logic [31:0]           w_wait;
    logic                  w_first;

    // dispatch arithmetic
    logic                  w_late;
    logic [31:0]           w_eff;
    logic [31:0]           w_rem32;
    logic [31:0]           w_q32;
    logic [31:0]           w_run32;
    logic [31:0]           w_end;
    logic                  w_done;

    assign w_fire        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_fire;
    assign w_load        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_load) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_in_type  <= s_axis_tuser;
            r_in_pid   <= s_axis_tdata[2:0];
            r_in_burst <= s_axis_tdata[18:3];
            r_in_rtime <= s_axis_tdata[50:19];
        end
    end

    mlfq_apb_regs u_regs (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_quantum_first  (w_q_first),
        .o_quantum_second (w_q_second)
    );

    for (genvar g = 0; g < LEVELS; g++) begin : g_lvl
        mlfq_level_fifo #(
            .DEPTH (NUM_PROCS)
        ) u_fifo (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_push    (w_push && (w_push_lvl == 2'(g))),
            .i_push_id (w_push_id),
            .i_pop     (w_pop && (w_sel_lvl == 2'(g))),
            .o_head_id (w_head[g]),
            .o_empty   (w_empty[g]),
            .o_count   (w_count[g])
        );
    end

    mlfq_proc_table #(
        .NUM_PROCS  (NUM_PROCS),
        .BURST_BITS (BURST_BITS)
    ) u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_addr       (w_addr),
        .i_wr_en      (w_tbl_we),
        .i_wr         (w_tbl_wr),
        .o_lvl        (w_rd_lvl),
        .o_queued     (w_rd_queued),
        .o_ever       (w_rd_ever),
        .o_rem        (w_rd_rem),
        .o_last       (w_rd_last),
        .o_queued_vec (w_queued_vec)
    );

    // highest non-empty level
    always_comb begin
        if (!w_empty[0]) begin
            w_sel_lvl = mlfq_pkg::LVL_TOP;
        end else if (!w_empty[1]) begin
            w_sel_lvl = mlfq_pkg::LVL_MID;
        end else begin
            w_sel_lvl = mlfq_pkg::LVL_LOW;
        end
    end

    assign w_pid_in   = PID_W'(r_in_pid);
    assign w_in_range = (32'(r_in_pid) < 32'(NUM_PROCS));
    assign w_addr     = (r_in_type == mlfq_pkg::REQ_DISPATCH) ? w_head[w_sel_lvl] : w_pid_in;

    // slice arithmetic; a late-ready process makes the CPU idle up to its ready time
    always_comb begin
        w_late  = (w_rd_last > r_clock);
        w_eff   = w_late ? w_rd_last : r_clock;
        w_rem32 = 32'(w_rd_rem);
        unique case (w_sel_lvl)
            mlfq_pkg::LVL_TOP: w_q32 = 32'(w_q_first);
            mlfq_pkg::LVL_MID: w_q32 = 32'(w_q_second);
            default:           w_q32 = 32'(w_q_first);
        endcase
        if (w_sel_lvl == mlfq_pkg::LVL_LOW || w_rem32 <= w_q32) begin
            w_run32 = w_rem32;
            w_done  = 1'b1;
        end else begin
            w_run32 = w_q32;
            w_done  = 1'b0;
        end
        w_end = w_eff + w_run32;
    end

    always_comb begin
        w_status    = mlfq_pkg::ST_OK;
        w_run_proc  = r_in_pid;
        w_run_level = mlfq_pkg::LVL_TOP;
        w_start     = '0;
        w_run_len   = '0;
        w_fin       = 1'b0;
        w_dem       = 1'b0;
        w_wait      = '0;
        w_first     = 1'b0;
        w_push      = 1'b0;
        w_push_lvl  = mlfq_pkg::LVL_TOP;
        w_push_id   = w_addr;
        w_pop       = 1'b0;
        w_tbl_we    = 1'b0;
        w_tbl_wr    = '0;
        n_clock     = r_clock;
        n_idle      = r_idle;
        if (r_in_type == mlfq_pkg::REQ_READY) begin
            if (!w_in_range) begin
                w_status = mlfq_pkg::ST_REJECT;
            end else if (w_rd_queued) begin
                w_status    = mlfq_pkg::ST_REJECT;
                w_run_level = w_rd_lvl;
            end else begin
                w_run_level      = w_rd_lvl;
                w_push           = w_fire;
                w_push_lvl       = w_rd_lvl;
                w_tbl_we         = w_fire;
                w_tbl_wr.en_rem  = 1'b1;
                w_tbl_wr.rem     = mlfq_pkg::BURST_MAX'(r_in_burst);
                w_tbl_wr.en_last = 1'b1;
                w_tbl_wr.last    = r_in_rtime;
                w_tbl_wr.en_q    = 1'b1;
                w_tbl_wr.q_val   = 1'b1;
            end
        end else if (&w_empty) begin
            w_status   = mlfq_pkg::ST_EMPTY;
            w_run_proc = '0;
        end else begin
            w_pop            = w_fire;
            w_run_proc       = 3'(w_addr);
            w_run_level      = w_sel_lvl;
            w_start          = w_eff;
            w_run_len        = w_run32[15:0];
            w_wait           = w_eff - w_rd_last;
            w_first          = !w_rd_ever;
            n_clock          = w_end;
            n_idle           = w_late ? r_idle + (w_rd_last - r_clock) : r_idle;
            w_tbl_we         = w_fire;
            w_tbl_wr.en_ever = 1'b1;
            if (w_done) begin
                w_fin          = 1'b1;
                w_tbl_wr.en_q  = 1'b1;
                w_tbl_wr.q_val = 1'b0;
            end else begin
                w_dem            = 1'b1;
                w_push           = w_fire;
                w_push_lvl       = w_sel_lvl + 2'd1;
                w_tbl_wr.en_rem  = 1'b1;
                w_tbl_wr.rem     = w_rem32 - w_run32;
                w_tbl_wr.en_lvl  = 1'b1;
                w_tbl_wr.lvl     = w_sel_lvl + 2'd1;
                w_tbl_wr.en_last = 1'b1;
                w_tbl_wr.last    = w_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_clock     <= '0;
            r_idle      <= '0;
        end else begin
            if (w_fire) begin
                r_out_valid <= 1'b1;
                r_clock     <= n_clock;
                r_idle      <= n_idle;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_status <= w_status;
            r_out_data   <= {n_idle, w_first, w_wait, w_dem, w_fin, w_run_len,
                             w_start, w_run_level, w_run_proc};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

    // the number of queued processes equals the total fill of the three level queues
    a_queue_census: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_queued_vec) == 32'(w_count[0]) + 32'(w_count[1]) + 32'(w_count[2]))
        else $error("queued flags disagree with queue fill counts");

    // an empty input register always leaves room for a new transaction
    a_in_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> s_axis_tready)
        else $error("input stalled with empty input register");

    // the bottom level runs to completion, so a demotion never comes from it
    a_no_demote_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[54] |-> m_axis_tdata[4:3] != mlfq_pkg::LVL_LOW)
        else $error("demotion from bottom level");

    // a result is only produced from a held request
    a_fire_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(r_in_valid) && $rose(m_axis_tvalid) |-> 1'b0)
        else $error("result without a request");

endmodule

FILE: tb/sv/mlfq_three_level_dispatcher_core_test.sv
// Self-checking testbench for the three-level feedback queue dispatcher core.
// Streams ready/dispatch requests under random backpressure, predicts every result in place.
// Depends on mlfq_pkg and mlfq_three_level_dispatcher_core.
`timescale 1ns / 100ps

module mlfq_three_level_dispatcher_core_test;

    localparam int NPROC          = mlfq_pkg::NUM_PROCS_DEF;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic        req;
        logic [2:0]  pid;
        logic [15:0] burst;
        logic [31:0] rdy;
    } t_sched_req;

    typedef struct packed {
        mlfq_pkg::t_status status;
        logic [2:0]        proc;
        mlfq_pkg::t_lvl    level;
        logic [31:0]       start;
        logic [15:0]       run_len;
        logic              done;
        logic              demote;
        logic [31:0]       wait_add;
        logic              first;
        logic [31:0]       idle;
    } t_sched_result;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [55:0]                   s_axis_tdata  = '0;   // [2:0] proc_id, [18:3] burst_length,
                                                         // [50:19] ready_time, [55:51] zero
    logic                          s_axis_tuser  = 1'b0; // [0] req_type
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [119:0]                  m_axis_tdata;         // [2:0] run_proc, [4:3] run_level,
                                                         // [36:5] start_time, [52:37] run_length,
                                                         // [53] burst_finished, [54] demoted,
                                                         // [86:55] wait_added, [87] first_run,
                                                         // [119:88] idle_total
    logic [1:0]                    m_axis_tuser;         // [1:0] status
    logic                          psel          = 1'b0;
    logic                          penable       = 1'b0;
    logic                          pwrite        = 1'b0;
    logic [mlfq_pkg::APB_AW-1:0]   paddr         = '0;
    logic [mlfq_pkg::APB_DW-1:0]   pwdata        = '0;
    logic [mlfq_pkg::APB_DW-1:0]   prdata;
    logic                          pready;

    mlfq_three_level_dispatcher_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 i_clk = ~i_clk;

    // scheduler shadow state
    logic [15:0]    q_first  = mlfq_pkg::QUANTUM_FIRST_RST;
    logic [15:0]    q_second = mlfq_pkg::QUANTUM_SECOND_RST;
    logic [31:0]    cpu_clk  = '0;
    logic [31:0]    idle_acc = '0;
    mlfq_pkg::t_lvl proc_lvl  [NPROC];
    logic [15:0]    rem_burst [NPROC];
    logic [31:0]    last_rdy  [NPROC];
    logic           is_queued [NPROC];
    logic           has_run   [NPROC];
    logic [2:0]     lvl_slot  [3][NPROC];
    int             lvl_head  [3];
    int             lvl_cnt   [3];

    t_sched_req    pending_reqs[$];
    t_sched_result expected_results[$];
    t_sched_req    feed_item;
    t_sched_result pred_result;
    t_sched_result got_result;
    t_sched_result want_result;

    bit          calm = 1'b0;
    int unsigned feed_gap = 0;
    int unsigned sink_stall = 0;
    int unsigned quiet_cycles = 0;
    int          err_cnt = 0;
    int          n_accepted = 0;
    int          n_results = 0;
    int          n_dispatch = 0;
    int          n_demote = 0;
    int          n_reject = 0;
    int          n_empty = 0;
    int          n_settings = 1;

    initial begin
        for (int i = 0; i < NPROC; i++) begin
            proc_lvl[i]  = mlfq_pkg::LVL_TOP;
            rem_burst[i] = '0;
            last_rdy[i]  = '0;
            is_queued[i] = 1'b0;
            has_run[i]   = 1'b0;
        end
        for (int l = 0; l < 3; l++) begin
            lvl_head[l] = 0;
            lvl_cnt[l]  = 0;
        end
    end

    function automatic void lvl_push(int lvl, logic [2:0] p);
        lvl_slot[lvl][(lvl_head[lvl] + lvl_cnt[lvl]) % NPROC] = p;
        lvl_cnt[lvl]++;
    endfunction

    function automatic t_sched_result predict_sched_step(logic req, logic [2:0] pid,
                                                         logic [15:0] burst, logic [31:0] rdy);
        t_sched_result r;
        int            sel;
        logic [2:0]    p;
        logic [15:0]   quantum;
        logic [15:0]   run;
        r = '0;
        if (req == mlfq_pkg::REQ_READY) begin
            r.proc = pid;
            if (is_queued[pid]) begin
                r.status = mlfq_pkg::ST_REJECT;
                r.level  = proc_lvl[pid];
                n_reject++;
            end else begin
                rem_burst[pid] = burst;
                last_rdy[pid]  = rdy;
                is_queued[pid] = 1'b1;
                lvl_push(proc_lvl[pid], pid);
                r.status = mlfq_pkg::ST_OK;
                r.level  = proc_lvl[pid];
            end
        end else begin
            sel = 3;
            for (int l = 2; l >= 0; l--)
                if (lvl_cnt[l] != 0) sel = l;
            if (sel == 3) begin
                r.status = mlfq_pkg::ST_EMPTY;
                n_empty++;
            end else begin
                n_dispatch++;
                p = lvl_slot[sel][lvl_head[sel]];
                lvl_head[sel] = (lvl_head[sel] + 1) % NPROC;
                lvl_cnt[sel]--;
                // CPU sits idle until the process is actually ready
                if (last_rdy[p] > cpu_clk) begin
                    idle_acc += last_rdy[p] - cpu_clk;
                    cpu_clk   = last_rdy[p];
                end
                r.status   = mlfq_pkg::ST_OK;
                r.proc     = p;
                r.level    = mlfq_pkg::t_lvl'(sel);
                r.start    = cpu_clk;
                r.wait_add = cpu_clk - last_rdy[p];
                r.first    = !has_run[p];
                has_run[p] = 1'b1;
                quantum = (sel == mlfq_pkg::LVL_TOP) ? q_first : q_second;
                if (sel != mlfq_pkg::LVL_LOW && rem_burst[p] > quantum) begin
                    run          = quantum;
                    rem_burst[p] = rem_burst[p] - quantum;
                    proc_lvl[p]  = mlfq_pkg::t_lvl'(sel + 1);
                    cpu_clk      = cpu_clk + run;
                    last_rdy[p]  = cpu_clk;
                    lvl_push(sel + 1, p);
                    r.demote = 1'b1;
                    n_demote++;
                end else begin
                    run          = rem_burst[p];
                    cpu_clk      = cpu_clk + run;
                    is_queued[p] = 1'b0;
                    r.done       = 1'b1;
                end
                r.run_len = run;
            end
        end
        r.idle = idle_acc;
        return r;
    endfunction

    function automatic string fmt_result(t_sched_result r);
        return {$sformatf("st=%0d p=%0d lvl=%0d start=%h run=%0d ",
                          r.status, r.proc, r.level, r.start, r.run_len),
                $sformatf("fin=%0b dem=%0b wait=%h first=%0b idle=%h",
                          r.done, r.demote, r.wait_add, r.first, r.idle)};
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            feed_gap      <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                pred_result = predict_sched_step(s_axis_tuser, s_axis_tdata[2:0],
                                                 s_axis_tdata[18:3], s_axis_tdata[50:19]);
                expected_results.insert(expected_results.size(), pred_result);
                n_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (feed_gap != 0) begin
                    feed_gap      <= feed_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    feed_item = pending_reqs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= feed_item.req;
                    s_axis_tdata  <= {5'b0, feed_item.rdy, feed_item.burst, feed_item.pid};
                    if (!calm && $urandom_range(0, 4) == 0)
                        feed_gap <= $urandom_range(1, 11);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_stall    <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_results++;
                got_result.status   = m_axis_tuser;
                got_result.proc     = m_axis_tdata[2:0];
                got_result.level    = m_axis_tdata[4:3];
                got_result.start    = m_axis_tdata[36:5];
                got_result.run_len  = m_axis_tdata[52:37];
                got_result.done     = m_axis_tdata[53];
                got_result.demote   = m_axis_tdata[54];
                got_result.wait_add = m_axis_tdata[86:55];
                got_result.first    = m_axis_tdata[87];
                got_result.idle     = m_axis_tdata[119:88];
                if (expected_results.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("ERROR: unexpected result transaction: %s",
                                 fmt_result(got_result));
                end else begin
                    want_result = expected_results.pop_front();
                    if (got_result !== want_result) begin
                        err_cnt++;
                        if (err_cnt <= 10) begin
                            $display("ERROR: result %0d mismatch", n_results);
                            $display("  expected %s", fmt_result(want_result));
                            $display("  actual   %s", fmt_result(got_result));
                        end
                    end
                end
            end
            if (sink_stall != 0) begin
                sink_stall    <= sink_stall - 1;
                m_axis_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                sink_stall    <= $urandom_range(0, 10);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no transaction for %0d cycles, %0d results still pending",
                     WATCHDOG_LIMIT, expected_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_req(logic req, logic [2:0] pid, logic [15:0] burst, logic [31:0] rdy);
        t_sched_req t;
        t.req   = req;
        t.pid   = pid;
        t.burst = burst;
        t.rdy   = rdy;
        pending_reqs.insert(pending_reqs.size(), t);
    endtask

    task automatic push_random_req();
        t_sched_req t;
        t.req   = mlfq_pkg::REQ_DISPATCH;
        t.pid   = 3'($urandom_range(0, 7));
        t.burst = 16'($urandom);
        t.rdy   = $urandom;
        if ($urandom_range(0, 99) < 52) begin
            t.req = mlfq_pkg::REQ_READY;
            // mostly pick an idle process; the rest may hit the already-queued reject
            if ($urandom_range(0, 4) != 0)
                for (int k = 0; k < NPROC && is_queued[t.pid]; k++)
                    t.pid = t.pid + 3'd1;
            if ($urandom_range(0, 5) != 0)
                t.burst = 16'($urandom_range(1, 40));
            case ($urandom_range(0, 7))
                0:       ;
                1, 2:    t.rdy = cpu_clk - $urandom_range(0, 30);
                default: t.rdy = cpu_clk + $urandom_range(0, 20);
            endcase
        end
        pending_reqs.insert(pending_reqs.size(), t);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic apb_write(logic reg_idx, logic [15:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {16'h0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        if (reg_idx == mlfq_pkg::REG_QUANTUM_FIRST) q_first = val;
        else q_second = val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (prdata !== {16'h0, val}) begin
            err_cnt++;
            if (err_cnt <= 10)
                $display("ERROR: readback of register %0d: expected %h, actual %h",
                         reg_idx, {16'h0, val}, prdata);
        end
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_phase(logic [15:0] qf, logic [15:0] qs, int count);
        wait_idle();
        apb_write(mlfq_pkg::REG_QUANTUM_FIRST, qf);
        apb_write(mlfq_pkg::REG_QUANTUM_SECOND, qs);
        n_settings++;
        repeat (count) begin
            while (pending_reqs.size() >= 2) @(negedge i_clk);
            push_random_req();
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty dispatch, zero burst, duplicate ready, exact-quantum finish,
        // demotion through all levels, no promotion, idle jumps and clock wrap
        queue_req(mlfq_pkg::REQ_DISPATCH, 3'd0, 16'h0000, 32'h0);
        queue_req(mlfq_pkg::REQ_READY,    3'd0, 16'h0000, 32'h0);
        queue_req(mlfq_pkg::REQ_READY,    3'd0, 16'h0005, 32'h9);
        queue_req(mlfq_pkg::REQ_DISPATCH, 3'd0, 16'h0000, 32'h0);
        queue_req(mlfq_pkg::REQ_READY,    3'd1, 16'd12,   32'h3);
        queue_req(mlfq_pkg::REQ_READY,    3'd7, 16'hFFFF, 32'hFFFF_FFF0);
        queue_req(mlfq_pkg::REQ_READY,    3'd2, 16'd5,    32'h0);
        queue_req(mlfq_pkg::REQ_DISPATCH, 3'd7, 16'hFFFF, 32'hFFFF_FFFF);
        queue_req(mlfq_pkg::REQ_DISPATCH, 3'd0, 16'h0000, 32'h0);
        queue_req(mlfq_pkg::REQ_DISPATCH, 3'd0, 16'h0000, 32'h0);
        queue_req(mlfq_pkg::REQ_DISPATCH, 3'd0, 16'h0000, 32'h0);
        queue_req(mlfq_pkg::REQ_DISPATCH, 3'd0, 16'h0000, 32'h0);
        queue_req(mlfq_pkg::REQ_READY,    3'd7, 16'd3,    32'h10);
        queue_req(mlfq_pkg::REQ_DISPATCH, 3'd0, 16'h0000, 32'h0);
        queue_req(mlfq_pkg::REQ_READY,    3'd1, 16'd20,   32'h2);
        queue_req(mlfq_pkg::REQ_READY,    3'd5, 16'd1,    32'hFFFF_FFFF);
        queue_req(mlfq_pkg::REQ_DISPATCH, 3'd0, 16'h0000, 32'h0);
        queue_req(mlfq_pkg::REQ_DISPATCH, 3'd0, 16'h0000, 32'h0);
        queue_req(mlfq_pkg::REQ_DISPATCH, 3'd0, 16'h0000, 32'h0);
        queue_req(mlfq_pkg::REQ_DISPATCH, 3'd0, 16'h0000, 32'h0);
        queue_req(mlfq_pkg::REQ_READY,    3'd6, 16'hAAAA, 32'h5555_5555);
        queue_req(mlfq_pkg::REQ_DISPATCH, 3'd0, 16'h0000, 32'h0);

        repeat (90) begin
            while (pending_reqs.size() >= 2) @(negedge i_clk);
            push_random_req();
        end
        run_phase(16'd1, 16'd1, 80);
        run_phase(16'hFFFF, 16'hFFFF, 60);
        run_phase(16'd1, 16'hFFFF, 60);
        wait_idle();
        calm = 1'b1;
        run_phase(16'($urandom_range(2, 8)), 16'($urandom_range(3, 30)), 110);

        wait_idle();
        repeat (8) @(negedge i_clk);
        err_cnt += expected_results.size();
        $display("Ran %0d requests over %0d quantum settings: %0d dispatches, %0d demotions,",
                 n_accepted, n_settings, n_dispatch, n_demote);
        $display("%0d rejected readies, %0d empty dispatches, idle total %0d, %0d errors",
                 n_reject, n_empty, idle_acc, err_cnt);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
